// File: rtl/q24alu_pkg.sv
// Shared definitions for the Q24.8 fixed-point ALU.
// Operation codes used by the ALU pipeline; no dependencies.
`default_nettype none

package q24alu_pkg;

    localparam int FUNC_BITS = 4;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_ADD     = 4'd0,
        FN_SUB     = 4'd1,
        FN_MUL     = 4'd2,
        FN_DIV     = 4'd3,
        FN_GT      = 4'd4,
        FN_LT      = 4'd5,
        FN_GE      = 4'd6,
        FN_LE      = 4'd7,
        FN_EQ      = 4'd8,
        FN_NE      = 4'd9,
        FN_MIN     = 4'd10,
        FN_MAX     = 4'd11,
        FN_INC     = 4'd12,
        FN_DEC     = 4'd13,
        FN_TOINT   = 4'd14,
        FN_FROMINT = 4'd15
    } t_func;

endpackage

`default_nettype wire

// File: rtl/q24_8_fixed_point_alu_unit.sv
// Q24.8 fixed-point ALU top level: input stage, operand prep, a restoring divider
// with one quotient bit per stage, a split multiplier, packing and an output skid.
// Depends on q24alu_pkg.
`default_nettype none

// Signed fixed-point ALU, WORD_BITS wide with FRAC_BITS fraction bits (Q24.8 by
// default). One beat is accepted every cycle when o_stall is low, and every beat
// gives exactly one result beat, in order. Every operation alike takes the same
// path from accept to o_valid; its length is set by the divider, which retires
// one quotient bit per pipeline stage over WORD_BITS + FRAC_BITS stages. A full
// output register plus one skid entry decouple the sides: o_stall rises only
// once both are occupied, and the whole pipeline then holds until the output
// drains.
module q24_8_fixed_point_alu_unit #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  [3:0]                  i_func,
    input  wire  signed [WORD_BITS-1:0] i_operand_a,
    input  wire  signed [WORD_BITS-1:0] i_operand_b,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic signed [WORD_BITS-1:0] o_result_value,
    output logic                        o_compare_true,
    output logic                        o_divide_by_zero,
    output logic                        o_overflow
);

    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int DW     = W + F;          // dividend and quotient width
    localparam int MW     = 2 * W;          // product width
    localparam int PW     = 2 * W + F;      // common width for packing
    localparam int HL     = (W + 1) / 2;    // low half of a multiplier operand
    localparam int HH     = W - HL;
    localparam int S_LN0  = 2;              // first stage of the main lane
    localparam int S_MUL  = 6;              // stage where the product merges in
    localparam int S_FIN  = DW + 3;         // last stage, quotient merges in
    localparam logic [MW-1:0] RND = MW'((64'd1 << F) - 64'd1);

    typedef struct packed {
        logic                 valid;
        q24alu_pkg::t_func    func;
        logic                 neg;
        logic                 dz;
        logic [W-1:0]         res;
        logic                 cmp;
        logic                 ovf;
    } t_lane;

    typedef struct packed {
        logic [W-1:0] res;
        logic         ovf;
    } t_pack;

    // Signed magnitude to low W bits, with the does-not-fit flag.
    function automatic t_pack pack_mag(input logic neg, input logic [PW-1:0] q);
        t_pack        p;
        logic [W-1:0] lo;
        lo = q[W-1:0];
        if (neg) begin
            p.ovf = (|q[PW-1:W]) || (q[W-1] && (|q[W-2:0]));
            p.res = ~lo + W'(1);
        end else begin
            p.ovf = |q[PW-1:W-1];
            p.res = lo;
        end
        return p;
    endfunction

    logic adv;

    // stage 0: input capture
    logic              r_s0_valid;
    q24alu_pkg::t_func r_s0_func;
    logic [W-1:0]      r_s0_a;
    logic [W-1:0]      r_s0_b;

    // stage 1: magnitudes and single-adder operations
    logic              r_s1_valid;
    q24alu_pkg::t_func r_s1_func;
    logic              r_s1_sa;
    logic              r_s1_neg;
    logic              r_s1_dz;
    logic [W-1:0]      r_s1_mag_a;
    logic [W-1:0]      r_s1_mag_b;
    logic [W-1:0]      r_s1_res;
    logic              r_s1_cmp;
    logic              r_s1_ovf;

    logic [W-1:0]      n_s1_mag_a;
    logic [W-1:0]      n_s1_mag_b;
    logic [W-1:0]      n_s1_res;
    logic              n_s1_cmp;
    logic              n_s1_ovf;

    // main lane, stages S_LN0..S_FIN
    t_lane r_ln [S_LN0:S_FIN];
    t_lane n_ln [S_LN0:S_FIN];

    // multiplier
    logic [2*HL-1:0]   r_mp0;
    logic [W-1:0]      r_mp1;
    logic [W-1:0]      r_mp2;
    logic [2*HH-1:0]   r_mp3;
    logic [W:0]        r_mm_mid;
    logic [MW-1:0]     r_mm_cat;
    logic [MW-1:0]     r_mfull;
    logic [MW-1:0]     r_msh;

    // divider
    logic [W-1:0]      r_dv_rem [0:DW-1];
    logic [W-1:0]      r_dv_d   [0:DW-1];
    logic [DW-1:0]     r_dv_dq  [0:DW];
    logic [W-1:0]      n_dv_rem [0:DW-1];
    logic [DW-1:0]     n_dv_dq  [0:DW-1];

    // output register and skid entry
    t_lane r_out;
    t_lane r_skid;

    t_pack        pk_fi;
    t_pack        pk_mul;
    t_pack        pk_div;
    logic [W-1:0] ti_sh;

    assign adv     = !r_skid.valid;
    assign o_stall = r_skid.valid;

    // ---------------- stage 0 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= i_valid;
        end
        if (adv) begin
            r_s0_func <= q24alu_pkg::t_func'(i_func);
            r_s0_a    <= i_operand_a;
            r_s0_b    <= i_operand_b;
        end
    end

    // ---------------- stage 1 ----------------
    always_comb begin
        logic [W-1:0] y;
        logic [W-1:0] r;
        logic         sub;
        logic         sa;
        logic         sy;
        logic         lt;
        logic         gt;
        logic         eq;
        sa  = r_s0_a[W-1];
        sub = (r_s0_func == q24alu_pkg::FN_SUB) || (r_s0_func == q24alu_pkg::FN_DEC);
        y   = ((r_s0_func == q24alu_pkg::FN_INC) || (r_s0_func == q24alu_pkg::FN_DEC)) ?
              W'(1) : r_s0_b;
        sy  = y[W-1];
        r   = sub ? (r_s0_a - y) : (r_s0_a + y);
        lt  = $signed(r_s0_a) < $signed(r_s0_b);
        gt  = $signed(r_s0_b) < $signed(r_s0_a);
        eq  = r_s0_a == r_s0_b;

        n_s1_mag_a = sa ? (~r_s0_a + W'(1)) : r_s0_a;
        n_s1_mag_b = r_s0_b[W-1] ? (~r_s0_b + W'(1)) : r_s0_b;
        n_s1_res   = '0;
        n_s1_cmp   = 1'b0;
        n_s1_ovf   = 1'b0;
        case (r_s0_func)
            q24alu_pkg::FN_ADD,
            q24alu_pkg::FN_SUB,
            q24alu_pkg::FN_INC,
            q24alu_pkg::FN_DEC: begin
                n_s1_res = r;
                n_s1_ovf = (sub ? (sa != sy) : (sa == sy)) && (r[W-1] != sa);
            end
            q24alu_pkg::FN_GT:  n_s1_cmp = gt;
            q24alu_pkg::FN_LT:  n_s1_cmp = lt;
            q24alu_pkg::FN_GE:  n_s1_cmp = !lt;
            q24alu_pkg::FN_LE:  n_s1_cmp = !gt;
            q24alu_pkg::FN_EQ:  n_s1_cmp = eq;
            q24alu_pkg::FN_NE:  n_s1_cmp = !eq;
            q24alu_pkg::FN_MIN: n_s1_res = lt ? r_s0_a : r_s0_b;
            q24alu_pkg::FN_MAX: n_s1_res = gt ? r_s0_a : r_s0_b;
            default: begin
                n_s1_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= r_s0_valid;
        end
        if (adv) begin
            r_s1_func  <= r_s0_func;
            r_s1_sa    <= r_s0_a[W-1];
            r_s1_neg   <= r_s0_a[W-1] ^ r_s0_b[W-1];
            r_s1_dz    <= (r_s0_func == q24alu_pkg::FN_DIV) && (r_s0_b == '0);
            r_s1_mag_a <= n_s1_mag_a;
            r_s1_mag_b <= n_s1_mag_b;
            r_s1_res   <= n_s1_res;
            r_s1_cmp   <= n_s1_cmp;
            r_s1_ovf   <= n_s1_ovf;
        end
    end

    // ---------------- multiplier ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mp0    <= (2*HL)'(r_s1_mag_a[HL-1:0]) * (2*HL)'(r_s1_mag_b[HL-1:0]);
            r_mp1    <= W'(r_s1_mag_a[HL-1:0]) * W'(r_s1_mag_b[W-1:HL]);
            r_mp2    <= W'(r_s1_mag_a[W-1:HL]) * W'(r_s1_mag_b[HL-1:0]);
            r_mp3    <= (2*HH)'(r_s1_mag_a[W-1:HL]) * (2*HH)'(r_s1_mag_b[W-1:HL]);
            r_mm_mid <= (W+1)'(r_mp1) + (W+1)'(r_mp2);
            r_mm_cat <= {r_mp3, r_mp0};
            r_mfull  <= r_mm_cat + (MW'(r_mm_mid) << HL);
            // negative products round toward minus infinity
            r_msh    <= (r_mfull + (r_ln[4].neg ? RND : MW'(0))) >> F;
        end
    end

    // ---------------- divider ----------------
    always_comb begin
        logic [W:0] t;
        logic [W:0] diff;
        logic       ge;
        for (int k = 0; k < DW; k++) begin
            t           = {r_dv_rem[k], r_dv_dq[k][DW-1]};
            diff        = t - {1'b0, r_dv_d[k]};
            ge          = t >= {1'b0, r_dv_d[k]};
            n_dv_rem[k] = ge ? diff[W-1:0] : t[W-1:0];
            n_dv_dq[k]  = {r_dv_dq[k][DW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_rem[0] <= '0;
            r_dv_d[0]   <= r_s1_mag_b;
            r_dv_dq[0]  <= {r_s1_mag_a, F'(0)};
            for (int k = 0; k < DW; k++) begin
                r_dv_dq[k+1] <= n_dv_dq[k];
            end
            for (int k = 0; k < DW - 1; k++) begin
                r_dv_rem[k+1] <= n_dv_rem[k];
                r_dv_d[k+1]   <= r_dv_d[k];
            end
        end
    end

    // ---------------- main lane ----------------
    assign ti_sh  = r_s1_mag_a >> F;
    assign pk_fi  = pack_mag(r_s1_sa, PW'({r_s1_mag_a, F'(0)}));
    assign pk_mul = pack_mag(r_ln[S_MUL-1].neg, PW'(r_msh));
    assign pk_div = pack_mag(r_ln[S_FIN-1].neg, PW'(r_dv_dq[DW]));

    always_comb begin
        n_ln[S_LN0].valid = r_s1_valid;
        n_ln[S_LN0].func  = r_s1_func;
        n_ln[S_LN0].neg   = r_s1_neg;
        n_ln[S_LN0].dz    = r_s1_dz;
        n_ln[S_LN0].res   = r_s1_res;
        n_ln[S_LN0].cmp   = r_s1_cmp;
        n_ln[S_LN0].ovf   = r_s1_ovf;
        if (r_s1_func == q24alu_pkg::FN_TOINT) begin
            n_ln[S_LN0].res = r_s1_sa ? (~ti_sh + W'(1)) : ti_sh;
            n_ln[S_LN0].ovf = 1'b0;
        end else if (r_s1_func == q24alu_pkg::FN_FROMINT) begin
            n_ln[S_LN0].res = pk_fi.res;
            n_ln[S_LN0].ovf = pk_fi.ovf;
        end

        for (int k = S_LN0 + 1; k <= S_FIN; k++) begin
            n_ln[k] = r_ln[k-1];
        end

        if (r_ln[S_MUL-1].func == q24alu_pkg::FN_MUL) begin
            n_ln[S_MUL].res = pk_mul.res;
            n_ln[S_MUL].ovf = pk_mul.ovf;
        end

        if (r_ln[S_FIN-1].func == q24alu_pkg::FN_DIV) begin
            if (r_ln[S_FIN-1].dz) begin
                n_ln[S_FIN].res = '0;
                n_ln[S_FIN].ovf = 1'b0;
            end else begin
                n_ln[S_FIN].res = pk_div.res;
                n_ln[S_FIN].ovf = pk_div.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = S_LN0; k <= S_FIN; k++) begin
                r_ln[k].valid <= 1'b0;
            end
        end else if (adv) begin
            for (int k = S_LN0; k <= S_FIN; k++) begin
                r_ln[k] <= n_ln[k];
            end
        end
    end

    // ---------------- output register and skid ----------------
    // The last lane stage is taken whenever the pipe advances; it lands in the
    // output register, or in the skid entry when the output is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (!r_out.valid || !i_stall) begin
            if (r_skid.valid) begin
                r_out        <= r_skid;
                r_skid.valid <= 1'b0;
            end else begin
                r_out <= r_ln[S_FIN];
            end
        end else if (adv && r_ln[S_FIN].valid) begin
            r_skid <= r_ln[S_FIN];
        end
    end

    assign o_valid          = r_out.valid;
    assign o_result_value   = r_out.res;
    assign o_compare_true   = r_out.cmp;
    assign o_divide_by_zero = r_out.dz;
    assign o_overflow       = r_out.ovf;

`ifndef NO_ASSERTIONS
    a_skid_fill_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid.valid && !$past(r_skid.valid)) |-> $past(r_out.valid && i_stall))
        else $error("skid entry filled while output was free");

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |-> r_out.valid)
        else $error("skid entry holds a beat ahead of an empty output");

    a_hold_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |=> $stable(r_ln[S_FIN]) && $stable(r_s0_valid))
        else $error("pipeline moved while held");

    a_dz_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |->
            (o_result_value == '0) && !o_overflow && !o_compare_true)
        else $error("zero divisor beat carries a result");

    a_cmp_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_compare_true) |->
            (o_result_value == '0) && !o_overflow && !o_divide_by_zero)
        else $error("comparison beat carries a value");
`endif

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking bench for the Q24.8 fixed-point ALU: a queue-fed driver, a monitor
// and an in-bench predictor of every operation, with random idling on both sides.
// Depends on q24alu_pkg and q24_8_fixed_point_alu_unit.
`default_nettype none

module testbench;

    localparam int FRAC = 8;
    localparam int LATENCY = 32 + FRAC + 5;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_BEATS = 60;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam longint WIDE_MAX = 64'sd2147483647;
    localparam longint WIDE_MIN = -64'sd2147483648;

    typedef struct {
        q24alu_pkg::t_func  fn;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_alu_op;

    typedef struct {
        t_alu_op            op;
        logic signed [31:0] value;
        logic               cmp;
        logic               div_zero;
        logic               ovf;
    } t_alu_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [3:0]         i_func;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_result_value;
    logic               o_compare_true;
    logic               o_divide_by_zero;
    logic               o_overflow;

    t_alu_op     op_q[$];
    t_alu_result expected_q[$];
    logic        in_fire;
    int          accepted_ops;
    int          mismatches;
    int          cycle_count;

    q24_8_fixed_point_alu_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_value   (o_result_value),
        .o_compare_true   (o_compare_true),
        .o_divide_by_zero (o_divide_by_zero),
        .o_overflow       (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Exact math in 64 bits; the low word is kept and overflow flags a true
    // result outside the signed 32-bit range.
    function automatic t_alu_result alu_expect(t_alu_op op);
        t_alu_result r;
        longint sa;
        longint sb;
        longint wide;
        sa = op.a;
        sb = op.b;
        wide = 0;
        r.op = op;
        r.cmp = 1'b0;
        r.div_zero = 1'b0;
        case (op.fn)
            q24alu_pkg::FN_ADD:     wide = sa + sb;
            q24alu_pkg::FN_SUB:     wide = sa - sb;
            q24alu_pkg::FN_INC:     wide = sa + 1;
            q24alu_pkg::FN_DEC:     wide = sa - 1;
            q24alu_pkg::FN_MUL:     wide = (sa * sb) >>> FRAC;  // floor
            q24alu_pkg::FN_DIV: begin
                if (sb == 0) r.div_zero = 1'b1;
                else wide = (sa * 256) / sb;        // truncates toward zero
            end
            q24alu_pkg::FN_GT:      r.cmp = (sa > sb);
            q24alu_pkg::FN_LT:      r.cmp = (sa < sb);
            q24alu_pkg::FN_GE:      r.cmp = (sa >= sb);
            q24alu_pkg::FN_LE:      r.cmp = (sa <= sb);
            q24alu_pkg::FN_EQ:      r.cmp = (sa == sb);
            q24alu_pkg::FN_NE:      r.cmp = (sa != sb);
            q24alu_pkg::FN_MIN:     wide = (sa < sb) ? sa : sb;
            q24alu_pkg::FN_MAX:     wide = (sb < sa) ? sa : sb;
            q24alu_pkg::FN_TOINT:   wide = sa / 256;
            q24alu_pkg::FN_FROMINT: wide = sa * 256;
            default:                wide = 0;
        endcase
        r.value = wide[31:0];
        r.ovf = (wide > WIDE_MAX) || (wide < WIDE_MIN);
        return r;
    endfunction

    task automatic report_mismatch(string what, t_alu_op op, longint got, longint want);
        $display("mismatch %s: %s a=%h b=%h got %h want %h", what, op.fn.name(),
                 op.a, op.b, got, want);
        mismatches++;
    endtask

    task automatic queue_op(q24alu_pkg::t_func fn, logic signed [31:0] a,
                            logic signed [31:0] b);
        t_alu_op op;
        op.fn = fn;
        op.a = a;
        op.b = b;
        op_q.push_back(op);
    endtask

    function automatic logic signed [31:0] pick_operand();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $signed($urandom_range(0, 4095)) - 2048;
            6: begin
                case ($urandom_range(0, 5))
                    0: v = MAXV;
                    1: v = MINV;
                    2: v = 0;
                    3: v = -1;
                    4: v = 1;
                    default: v = MINV + 1;
                endcase
            end
            7:          v = ($signed($urandom_range(0, 511)) - 256) * 256;
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    // Phases by accepted beat count: none, sender idle, receiver stall, both light, none.
    function automatic int send_idle_pct(int n);
        case ((n / PHASE_BEATS) % 5)
            1:       return 75;
            3:       return 12;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(int n);
        case ((n / PHASE_BEATS) % 5)
            2:       return 75;
            3:       return 12;
            default: return 0;
        endcase
    endfunction

    // Driver: inputs change on the falling edge only.
    always @(negedge i_clk) begin : drive
        t_alu_op op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(accepted_ops)) begin
                op = op_q.pop_front();
                i_func      <= op.fn;
                i_operand_a <= op.a;
                i_operand_b <= op.b;
                i_valid     <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= i_rst_n && ($urandom_range(0, 99) < recv_stall_pct(accepted_ops));
    end

    // Monitor: input beats feed the predictor, output beats are checked in order.
    always @(posedge i_clk) begin : watch
        t_alu_op     op;
        t_alu_result want;
        in_fire <= i_valid && !o_stall;
        if (i_valid && !o_stall) begin
            op.fn = q24alu_pkg::t_func'(i_func);
            op.a = i_operand_a;
            op.b = i_operand_b;
            expected_q.push_back(alu_expect(op));
            accepted_ops++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                op.fn = q24alu_pkg::FN_ADD;
                op.a = 0;
                op.b = 0;
                report_mismatch("unexpected beat", op, o_result_value, 0);
            end else begin
                want = expected_q.pop_front();
                if (o_result_value !== want.value)
                    report_mismatch("value", want.op, o_result_value, want.value);
                if (o_compare_true !== want.cmp)
                    report_mismatch("compare", want.op, o_compare_true, want.cmp);
                if (o_divide_by_zero !== want.div_zero)
                    report_mismatch("div_zero", want.op, o_divide_by_zero, want.div_zero);
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", want.op, o_overflow, want.ovf);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic signed [31:0] a;
        logic signed [31:0] b;
        int                 pick;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_func       = '0;
        i_operand_a  = '0;
        i_operand_b  = '0;
        in_fire      = 1'b0;
        accepted_ops = 0;
        mismatches   = 0;
        cycle_count  = 0;

        // Directed: wrap-around, rounding direction, zero divisor, equal operands.
        queue_op(q24alu_pkg::FN_ADD, MAXV, 1);
        queue_op(q24alu_pkg::FN_ADD, MINV, -1);
        queue_op(q24alu_pkg::FN_SUB, MINV, 1);
        queue_op(q24alu_pkg::FN_SUB, 0, MINV);
        queue_op(q24alu_pkg::FN_MUL, MAXV, MAXV);
        queue_op(q24alu_pkg::FN_MUL, MINV, MINV);
        queue_op(q24alu_pkg::FN_MUL, -1, 1);
        queue_op(q24alu_pkg::FN_MUL, 32'sh180, -32'sh80);
        queue_op(q24alu_pkg::FN_DIV, 32'sh100, 0);
        queue_op(q24alu_pkg::FN_DIV, MINV, -1);
        queue_op(q24alu_pkg::FN_DIV, -1, 3);
        queue_op(q24alu_pkg::FN_DIV, MAXV, MINV);
        queue_op(q24alu_pkg::FN_GT, MAXV, MINV);
        queue_op(q24alu_pkg::FN_LT, MINV, MAXV);
        queue_op(q24alu_pkg::FN_GE, -5, -5);
        queue_op(q24alu_pkg::FN_LE, -5, -5);
        queue_op(q24alu_pkg::FN_EQ, MINV, MINV);
        queue_op(q24alu_pkg::FN_NE, 0, -1);
        queue_op(q24alu_pkg::FN_MIN, 7, 7);
        queue_op(q24alu_pkg::FN_MAX, MINV, MAXV);
        queue_op(q24alu_pkg::FN_INC, MAXV, 0);
        queue_op(q24alu_pkg::FN_DEC, MINV, 0);
        queue_op(q24alu_pkg::FN_TOINT, -1, MAXV);
        queue_op(q24alu_pkg::FN_TOINT, MINV, 0);
        queue_op(q24alu_pkg::FN_FROMINT, MAXV, 0);
        queue_op(q24alu_pkg::FN_FROMINT, MINV, 0);
        queue_op(q24alu_pkg::FN_FROMINT, -1, 5);

        for (int i = 0; i < 450; i++) begin
            a = pick_operand();
            b = pick_operand();
            pick = $urandom_range(0, 99);
            if (pick < 10) b = a;
            else if (pick < 15) b = 0;
            queue_op(q24alu_pkg::t_func'($urandom_range(0, 15)), a, b);
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_q.size() != 0 || i_valid) @(negedge i_clk);
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (2 * LATENCY) @(negedge i_clk);

        if (mismatches == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/q24alu_pkg.sv
rtl/q24_8_fixed_point_alu_unit.sv
test/testbench.sv
